// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only outside reset
`define NLM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every edge, reset included
`define NLM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/nlm_pkg.sv -----
package nlm_pkg;

    localparam int CFG_W        = 11;
    localparam int LABEL_W      = 8;
    localparam int HIT_W        = 10;
    localparam int MARK_W       = 2;
    localparam int HITS_N       = 4;
    localparam int WIN_N        = 9;
    localparam int APB_DW       = 32;
    localparam int APB_AW       = 3;
    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;

    localparam logic [LABEL_W-1:0] LBL_CAND = 8'd1;
    localparam logic [LABEL_W-1:0] LBL_MARK = 8'd2;

    typedef enum logic [0:0] {
        REG_FRAME_ROWS = 1'b0,
        REG_FRAME_COLS = 1'b1
    } reg_idx_t;

    typedef logic [MARK_W-1:0] mark_t;

    typedef struct packed {
        mark_t             mark;
        logic              first_col;
        logic              last_col;
        logic              last_row;
        logic              row_ge1;
        logic              row_ge2;
        logic [HIT_W-1:0]  row;
        logic [HIT_W-1:0]  col;
    } pix_info_t;

    typedef struct packed {
        logic [HITS_N-1:0] hits;
        logic [HIT_W-1:0]  row;
        logic [HIT_W-1:0]  col;
    } hit_bundle_t;

endpackage

// ----- rtl/nlm_ram.sv -----
module nlm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/nlm_window.sv -----
module nlm_window
    import nlm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    clear,
    input  logic                    fire,
    input  pix_info_t               info,
    input  logic [2*MARK_W-1:0]     line_rdata,
    output logic [2*MARK_W-1:0]     line_wdata,
    output hit_bundle_t             bundle
);

    mark_t win_reg  [WIN_N];
    mark_t win_next [WIN_N];
    mark_t up2;
    mark_t up1;
    logic  any_all;
    logic  any_right;
    logic  any_low;
    logic  any_low_right;

    always_comb begin
        up2 = info.row_ge2 ? line_rdata[2*MARK_W-1:MARK_W] : '0;
        up1 = info.row_ge1 ? line_rdata[MARK_W-1:0] : '0;
        for (int a = 0; a < 3; a++) begin
            win_next[a*3+0] = info.first_col ? '0 : win_reg[a*3+1];
            win_next[a*3+1] = info.first_col ? '0 : win_reg[a*3+2];
        end
        win_next[2] = up2;
        win_next[5] = up1;
        win_next[8] = info.mark;
    end

    assign line_wdata = {up1, info.mark};

    always_comb begin
        any_all = 1'b0;
        for (int i = 0; i < WIN_N; i++) begin
            any_all = any_all | win_next[i][1];
        end
        any_right     = win_next[1][1] | win_next[2][1] | win_next[4][1] |
                        win_next[5][1] | win_next[7][1] | win_next[8][1];
        any_low       = win_next[3][1] | win_next[4][1] | win_next[5][1] |
                        win_next[6][1] | win_next[7][1] | win_next[8][1];
        any_low_right = win_next[4][1] | win_next[5][1] | win_next[7][1] | win_next[8][1];

        bundle.hits[0] = info.row_ge1 & ~info.first_col & win_next[4][0] & any_all;
        bundle.hits[1] = info.row_ge1 & info.last_col & win_next[5][0] & any_right;
        bundle.hits[2] = info.last_row & ~info.first_col & win_next[7][0] & any_low;
        bundle.hits[3] = info.last_row & info.last_col & win_next[8][0] & any_low_right;
        bundle.row     = info.row;
        bundle.col     = info.col;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            for (int i = 0; i < WIN_N; i++) begin
                win_reg[i] <= '0;
            end
        end else if (fire) begin
            for (int i = 0; i < WIN_N; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

endmodule

// ----- rtl/nlm_out.sv -----
module nlm_out
    import nlm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  hit_bundle_t       bundle,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [HIT_W-1:0]  m_hit_row,
    output logic [HIT_W-1:0]  m_hit_col,
    output logic              m_run_end
);

    logic [HITS_N-1:0] hits_reg;
    logic [HITS_N-1:0] hits_next;
    logic [HIT_W-1:0]  row_reg;
    logic [HIT_W-1:0]  col_reg;
    logic [HITS_N-1:0] sel;
    logic [HITS_N-1:0] rest;
    logic              take;

    assign sel       = hits_reg & ~(hits_reg - HITS_N'(1));
    assign rest      = hits_reg & ~sel;
    assign m_valid   = |hits_reg;
    assign take      = m_valid & m_ready;
    assign free      = ~m_valid | (take & ~|rest);
    assign m_run_end = ~|rest;
    assign m_hit_row = (sel[0] | sel[1]) ? row_reg - HIT_W'(1) : row_reg;
    assign m_hit_col = (sel[0] | sel[2]) ? col_reg - HIT_W'(1) : col_reg;

    always_comb begin
        hits_next = hits_reg;
        if (load) begin
            hits_next = bundle.hits;
        end else if (take) begin
            hits_next = rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hits_reg <= '0;
        end else begin
            hits_reg <= hits_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            row_reg <= bundle.row;
            col_reg <= bundle.col;
        end
    end

endmodule

// ----- rtl/neighbourhood_label_match.sv -----
// Finds label-1 pixels whose clipped 3x3 neighborhood holds a label-2 pixel in a
// raster-order label stream. One pixel is taken per clock while s_ready is high.
// A pixel's column is looked up in a simple dual-port line RAM (marks of the two
// rows above) on the beat it is taken; the window update, hit test and write-back
// happen when it leaves that lookup stage, and its hits are registered in the
// output stage before reaching the result port. A last-row or last-column pixel
// can give more than one hit (four at most, at the frame's last pixel), sent one
// per clock while m_ready is high, in raster order with m_run_end on the last.
// Input stalls until the last is taken. Writing either size register restarts the
// frame at row 0, column 0; sizes are clamped to 2..MAX_ROWS and 2..MAX_COLS.
`include "assert_macros.svh"

module neighbourhood_label_match
    import nlm_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [LABEL_W-1:0] s_pixel_label,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [HIT_W-1:0]   m_hit_row,
    output logic [HIT_W-1:0]   m_hit_col,
    output logic               m_run_end
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CSZ_W  = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int RSZ_W  = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

    logic [CFG_W-1:0] frame_rows_reg;
    logic [CFG_W-1:0] frame_cols_reg;
    logic [RSZ_W-1:0] rows_eff;
    logic [CSZ_W-1:0] cols_eff;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    logic             s_take;
    logic             last_col;
    logic             last_row;
    pix_info_t        info;

    logic             p1_valid_reg;
    pix_info_t        p1_info_reg;
    logic [COL_W-1:0] p1_col_reg;
    logic             p1_fire;
    logic             out_free;

    logic [2*MARK_W-1:0] line_rdata;
    logic [2*MARK_W-1:0] line_wdata;
    hit_bundle_t         bundle;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_ROWS: prdata = APB_DW'(frame_rows_reg);
            REG_FRAME_COLS: prdata = APB_DW'(frame_cols_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_rows_reg <= CFG_W'(2);
            frame_cols_reg <= CFG_W'(2);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_ROWS: frame_rows_reg <= pwdata[CFG_W-1:0];
                REG_FRAME_COLS: frame_cols_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        rows_eff = RSZ_W'(frame_rows_reg);
        if (rows_eff < RSZ_W'(2)) begin
            rows_eff = RSZ_W'(2);
        end else if (rows_eff > RSZ_W'(MAX_ROWS)) begin
            rows_eff = RSZ_W'(MAX_ROWS);
        end
        cols_eff = CSZ_W'(frame_cols_reg);
        if (cols_eff < CSZ_W'(2)) begin
            cols_eff = CSZ_W'(2);
        end else if (cols_eff > CSZ_W'(MAX_COLS)) begin
            cols_eff = CSZ_W'(MAX_COLS);
        end
    end

    // position counters and line RAM lookup
    assign p1_fire  = p1_valid_reg & out_free;
    assign s_ready  = ~p1_valid_reg | p1_fire;
    assign s_take   = s_valid & s_ready;
    assign last_col = (CSZ_W'(col_reg) + CSZ_W'(1)) == cols_eff;
    assign last_row = (RSZ_W'(row_reg) + RSZ_W'(1)) == rows_eff;

    always_comb begin
        info.mark      = {s_pixel_label == LBL_MARK, s_pixel_label == LBL_CAND};
        info.first_col = col_reg == '0;
        info.last_col  = last_col;
        info.last_row  = last_row;
        info.row_ge1   = row_reg != '0;
        info.row_ge2   = row_reg > ROW_W'(1);
        info.row       = HIT_W'(row_reg);
        info.col       = HIT_W'(col_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (s_take) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p1_valid_reg <= s_take;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            p1_info_reg <= info;
            p1_col_reg  <= col_reg;
        end
    end

    nlm_ram #(
        .WIDTH (2*MARK_W),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (p1_fire),
        .waddr (p1_col_reg),
        .wdata (line_wdata),
        .re    (s_take),
        .raddr (col_reg),
        .rdata (line_rdata)
    );

    nlm_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (cfg_wr),
        .fire       (p1_fire),
        .info       (p1_info_reg),
        .line_rdata (line_rdata),
        .line_wdata (line_wdata),
        .bundle     (bundle)
    );

    nlm_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (p1_fire),
        .bundle    (bundle),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_hit_row (m_hit_row),
        .m_hit_col (m_hit_col),
        .m_run_end (m_run_end)
    );

    `NLM_ASSERT(a_ram_no_overlap, aclk, aresetn, (p1_fire && s_take) |-> (p1_col_reg != col_reg), "line RAM read and write hit the same column")
    `NLM_ASSERT(a_stall_has_item, aclk, aresetn, !s_ready |-> p1_valid_reg, "input stalled with empty lookup stage")
    `NLM_ASSERT(a_col_in_frame, aclk, aresetn, CSZ_W'(col_reg) < cols_eff, "column counter outside frame")
    `NLM_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> (!m_valid && !p1_valid_reg), "pipeline not empty after reset")

endmodule

// ----- tb/neighbourhood_label_match_tb.sv -----
`timescale 1ns / 1ps

module neighbourhood_label_match_tb;
    import nlm_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 260;
    localparam int LARGE_PIXELS  = 48;
    localparam int MAX_PRINTS    = 50;

    typedef struct {
        logic [HIT_W-1:0] row;
        logic [HIT_W-1:0] col;
        logic             run_end;
    } hit_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [APB_AW-1:0]  paddr         = '0;
    logic [APB_DW-1:0]  pwdata        = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [LABEL_W-1:0] s_pixel_label = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [HIT_W-1:0]   m_hit_row;
    logic [HIT_W-1:0]   m_hit_col;
    logic               m_run_end;

    logic [CFG_W-1:0]   rows_reg;
    logic [CFG_W-1:0]   cols_reg;
    mark_t              line_marks [2*MAX_COLS_DEF];
    mark_t              win_marks [WIN_N];
    int unsigned        cur_row;
    int unsigned        cur_col;
    hit_t               hits_due [$];

    int                 mismatches = 0;
    int                 cycles     = 0;
    int                 ready_hold = 0;
    bit                 gaps_on    = 1'b1;
    bit                 stalls_on  = 1'b1;

    neighbourhood_label_match u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_label (s_pixel_label),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit_row     (m_hit_row),
        .m_hit_col     (m_hit_col),
        .m_run_end     (m_run_end)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("neighbourhood_label_match_tb failed");
            $finish;
        end
    end

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // result-side backpressure: alternate ready bursts and stalls
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold = ready_hold - 1;
        end else if (!stalls_on) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= !m_ready;
            ready_hold = m_ready ? idle_len() : $urandom_range(0, 8);
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS) $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    always @(posedge aclk) begin : check_hits
        hit_t want;
        if (aresetn && m_valid && m_ready) begin
            if (hits_due.size() == 0) begin
                report_mismatch($sformatf("unexpected hit row %0d col %0d run_end %0b",
                                          m_hit_row, m_hit_col, m_run_end));
            end else begin
                want = hits_due.pop_front();
                if (m_hit_row !== want.row)
                    report_mismatch($sformatf("hit_row %0d, want %0d", m_hit_row, want.row));
                if (m_hit_col !== want.col)
                    report_mismatch($sformatf("hit_col %0d, want %0d", m_hit_col, want.col));
                if (m_run_end !== want.run_end)
                    report_mismatch($sformatf("run_end %0b, want %0b at row %0d col %0d",
                                              m_run_end, want.run_end, want.row, want.col));
            end
        end
    end

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic bit window_hit(input int r0, input int c0, input int crow, input int ccol);
        if (!win_marks[crow*3+ccol][0]) return 1'b0;
        for (int a = r0; a < 3; a++)
            for (int b = c0; b < 3; b++)
                if (win_marks[a*3+b][1]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void predict_hits(input logic [LABEL_W-1:0] label);
        int unsigned rows, cols, r, c, here, above;
        mark_t       mk, up2, up1;
        hit_t        found [$];
        rows  = clamp_dim(rows_reg, MAX_ROWS_DEF);
        cols  = clamp_dim(cols_reg, MAX_COLS_DEF);
        r     = cur_row;
        c     = cur_col;
        mk    = {label == LBL_MARK, label == LBL_CAND};
        here  = (r % 2) * MAX_COLS_DEF + c;
        above = ((r + 1) % 2) * MAX_COLS_DEF + c;
        up2   = (r >= 2) ? line_marks[here] : '0;
        up1   = (r >= 1) ? line_marks[above] : '0;
        line_marks[here] = mk;

        for (int a = 0; a < 3; a++) begin
            win_marks[a*3]   = win_marks[a*3+1];
            win_marks[a*3+1] = win_marks[a*3+2];
            if (c == 0) begin
                win_marks[a*3]   = '0;
                win_marks[a*3+1] = '0;
            end
        end
        win_marks[2] = up2;
        win_marks[5] = up1;
        win_marks[8] = mk;

        if (r >= 1) begin
            if (c >= 1 && window_hit(0, 0, 1, 1))
                found.push_back('{HIT_W'(r - 1), HIT_W'(c - 1), 1'b0});
            if (c + 1 == cols && window_hit(0, 1, 1, 2))
                found.push_back('{HIT_W'(r - 1), HIT_W'(c), 1'b0});
        end
        if (r + 1 == rows) begin
            if (c >= 1 && window_hit(1, 0, 2, 1))
                found.push_back('{HIT_W'(r), HIT_W'(c - 1), 1'b0});
            if (c + 1 == cols && window_hit(1, 1, 2, 2))
                found.push_back('{HIT_W'(r), HIT_W'(c), 1'b0});
        end
        if (found.size() > 0) found[found.size()-1].run_end = 1'b1;
        foreach (found[i]) hits_due.push_back(found[i]);

        c++;
        if (c >= cols) begin
            c = 0;
            r++;
            if (r >= rows) r = 0;
        end
        cur_row = r;
        cur_col = c;
    endfunction

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (hits_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_size(input reg_idx_t idx, input logic [CFG_W-1:0] dim);
        logic [APB_DW-1:0] word;
        wait_idle();
        word = ($urandom() & ~32'h7FF) | APB_DW'(dim);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FRAME_ROWS) rows_reg = word[CFG_W-1:0];
        else cols_reg = word[CFG_W-1:0];
        cur_row = 0;
        cur_col = 0;
        foreach (win_marks[i]) win_marks[i] = '0;
    endtask

    task automatic send_pixel(input logic [LABEL_W-1:0] label);
        int gap;
        gap = gaps_on ? idle_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_label <= label;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_hits(label);
    endtask

    function automatic logic [LABEL_W-1:0] pick_label();
        case ($urandom_range(0, 9))
            0, 1, 2: return LBL_CAND;
            3, 4:    return LBL_MARK;
            5, 6:    return '0;
            default: return LABEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return CFG_W'($urandom_range(0, 1));
        if (pick == 1) return CFG_W'($urandom_range(7, 12));
        return CFG_W'($urandom_range(2, 6));
    endfunction

    task automatic send_pixels(input int count);
        repeat (count) send_pixel(pick_label());
    endtask

    task automatic test_default_size();
        logic [LABEL_W-1:0] labels [8] = '{LBL_CAND, LBL_MARK, 8'd0, 8'd0,
                                          LBL_CAND, LBL_CAND, LBL_CAND, LBL_MARK};
        foreach (labels[i]) send_pixel(labels[i]);
        wait_idle();
    endtask

    task automatic test_label_extremes();
        logic [LABEL_W-1:0] labels [9] = '{8'd1, 8'd255, 8'd1,
                                          8'd128, 8'd2, 8'd1,
                                          8'd1, 8'd1, 8'd1};
        write_size(REG_FRAME_ROWS, 11'd3);
        write_size(REG_FRAME_COLS, 11'd3);
        foreach (labels[i]) send_pixel(labels[i]);
        wait_idle();
    endtask

    task automatic test_size_clamp_low();
        logic [LABEL_W-1:0] labels [4] = '{LBL_MARK, LBL_CAND, LBL_CAND, 8'd254};
        write_size(REG_FRAME_ROWS, 11'd0);
        write_size(REG_FRAME_COLS, 11'd1);
        foreach (labels[i]) send_pixel(labels[i]);
        wait_idle();
    endtask

    task automatic test_largest_sizes();
        gaps_on   = 1'b0;
        stalls_on = 1'b1;
        write_size(REG_FRAME_ROWS, 11'd2);
        write_size(REG_FRAME_COLS, 11'd2047);
        send_pixels(LARGE_PIXELS);
        stalls_on = 1'b0;
        write_size(REG_FRAME_ROWS, 11'd1500);
        write_size(REG_FRAME_COLS, 11'd2);
        send_pixels(LARGE_PIXELS);
        wait_idle();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int sent, count;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            write_size(REG_FRAME_ROWS, pick_dim());
            write_size(REG_FRAME_COLS, pick_dim());
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            count = clamp_dim(rows_reg, MAX_ROWS_DEF) * clamp_dim(cols_reg, MAX_COLS_DEF);
            count = count * $urandom_range(1, 2);
            // cut the frame short so the next size write restarts it mid-frame
            if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
            send_pixels(count);
            sent += count;
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        rows_reg = 11'd2;
        cols_reg = 11'd2;
        cur_row  = 0;
        cur_col  = 0;
        foreach (line_marks[i]) line_marks[i] = '0;
        foreach (win_marks[i]) win_marks[i] = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_size();
        test_label_extremes();
        test_size_clamp_low();
        test_random_frames();
        test_largest_sizes();

        wait_idle();
        if (mismatches == 0) begin
            $display("neighbourhood_label_match_tb passed");
        end else begin
            $display("neighbourhood_label_match_tb failed");
        end
        $finish;
    end

endmodule
